>>> rtl/core/ifl_pkg.sv
package ifl_pkg;

  // list geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int POS_W = 6;
  localparam int CMD_W = 3;
  localparam int ST_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // control broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

>>> rtl/core/ifl_cell.sv
module ifl_cell (
  input  logic                          clk,
  input  logic [ifl_pkg::IDX_W-1:0]     idx,
  input  ifl_pkg::cell_ctl_t            ctl,
  input  logic [ifl_pkg::WORD_W-1:0]    left_data,
  input  logic [ifl_pkg::WORD_W-1:0]    right_data,
  input  logic [ifl_pkg::WORD_W-1:0]    rd_in,
  output logic [ifl_pkg::WORD_W-1:0]    data,
  output logic [ifl_pkg::WORD_W-1:0]    rd_out
);

  logic [ifl_pkg::WORD_W-1:0] data_r;
  logic [ifl_pkg::WORD_W-1:0] data_nxt;

  // shift toward the tail on insert, toward the head on remove
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx > ctl.pos) begin
        data_nxt = left_data;
      end else if (idx == ctl.pos) begin
        data_nxt = ctl.word;
      end
    end
    if (ctl.rem && (idx >= ctl.pos)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // selected word rides the or-chain toward the tail
  assign rd_out = rd_in | ((idx == ctl.pos) ? data_r : '0);
  assign data   = data_r;

endmodule

>>> rtl/core/indexed_fifo_list_core.sv
// channel | dir | ports                                        | handshake
// in      | in  | in_command, in_value, in_position            | in_valid / in_stall
// out     | out | out_result_value, out_status, out_entry_count | out_valid / out_stall
//
// one command per cycle while in_stall is low; its result beat is registered and shows in the next cycle
// all cells update in the same cycle through a row of shifting cells
// rst_n (synchronous) clears the entry count and the output valid; words are not cleared
// in_stall rises only while a result beat sits in the output register and out_stall holds it
module indexed_fifo_list_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ifl_pkg::CMD_W-1:0]          in_command,
  input  logic signed [ifl_pkg::WORD_W-1:0]  in_value,
  input  logic signed [ifl_pkg::POS_W-1:0]   in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ifl_pkg::WORD_W-1:0]  out_result_value,
  output logic [ifl_pkg::ST_W-1:0]           out_status,
  output logic [ifl_pkg::CNT_W-1:0]          out_entry_count
);

  logic                              accept;
  logic [ifl_pkg::CNT_W-1:0]         occ_r;
  logic [ifl_pkg::CNT_W-1:0]         occ_nxt;
  logic                              full;
  logic                              empty;
  logic signed [ifl_pkg::POS_W-1:0]  occ_s;
  logic                              pos_in_list;
  logic                              pos_ins_ok;
  logic                              is_append;
  ifl_pkg::cell_ctl_t                ctl;
  logic [ifl_pkg::WORD_W-1:0]        rd_word;
  logic [ifl_pkg::WORD_W-1:0]        res_value;
  logic [ifl_pkg::ST_W-1:0]          res_status;

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [ifl_pkg::WORD_W-1:0]        out_value_r;
  logic [ifl_pkg::ST_W-1:0]          out_status_r;
  logic [ifl_pkg::CNT_W-1:0]         out_count_r;

  logic [ifl_pkg::WORD_W-1:0]        cell_data [ifl_pkg::DEPTH];
  logic [ifl_pkg::WORD_W-1:0]        rd_chain  [ifl_pkg::DEPTH+1];

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // range checks
  assign full        = (occ_r == ifl_pkg::CNT_W'(ifl_pkg::DEPTH));
  assign empty       = (occ_r == '0);
  assign occ_s       = $signed({{(ifl_pkg::POS_W-ifl_pkg::CNT_W){1'b0}}, occ_r});
  assign pos_in_list = !in_position[ifl_pkg::POS_W-1] && (in_position < occ_s);
  assign is_append   = (in_position == -ifl_pkg::POS_W'(1));
  assign pos_ins_ok  = is_append || (!in_position[ifl_pkg::POS_W-1] && (in_position <= occ_s));

  // command decode into the cell broadcast, result and next count
  always_comb begin
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.pos    = in_position[ifl_pkg::IDX_W-1:0];
    ctl.word   = in_value;
    res_value  = '0;
    res_status = ifl_pkg::ST_OK;
    occ_nxt    = occ_r;
    case (in_command)
      ifl_pkg::CMD_PUSH: begin
        ctl.pos = occ_r[ifl_pkg::IDX_W-1:0];
        if (full) begin
          res_status = ifl_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      ifl_pkg::CMD_PULL: begin
        ctl.pos = '0;
        if (empty) begin
          res_status = ifl_pkg::ST_EMPTY;
        end else begin
          ctl.rem   = 1'b1;
          res_value = rd_word;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      ifl_pkg::CMD_INSERT: begin
        if (is_append) begin
          ctl.pos = occ_r[ifl_pkg::IDX_W-1:0];
        end
        if (!pos_ins_ok) begin
          res_status = ifl_pkg::ST_RANGE;
        end else if (full) begin
          res_status = ifl_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      ifl_pkg::CMD_REMOVE: begin
        if (!pos_in_list) begin
          res_status = ifl_pkg::ST_RANGE;
        end else begin
          ctl.rem   = 1'b1;
          res_value = rd_word;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      ifl_pkg::CMD_READ: begin
        if (!pos_in_list) begin
          res_status = ifl_pkg::ST_RANGE;
        end else begin
          res_value = rd_word;
        end
      end
      ifl_pkg::CMD_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl.ins = 1'b0;
      ctl.rem = 1'b0;
      occ_nxt = occ_r;
    end
  end

  // row of cells, head at index 0
  assign rd_chain[0] = '0;
  assign rd_word     = rd_chain[ifl_pkg::DEPTH];

  for (genvar i = 0; i < ifl_pkg::DEPTH; i++) begin : g_cell
    logic [ifl_pkg::WORD_W-1:0] left_w;
    logic [ifl_pkg::WORD_W-1:0] right_w;
    if (i == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == ifl_pkg::DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    ifl_cell u_cell (
      .clk        (clk),
      .idx        (ifl_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .left_data  (left_w),
      .right_data (right_w),
      .rd_in      (rd_chain[i]),
      .data       (cell_data[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

  // output register
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= occ_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;

`ifndef SYNTHESIS
  // count stays within the list depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= ifl_pkg::CNT_W'(ifl_pkg::DEPTH))
    else $error("entry count beyond depth");

  // a successful push grows the list by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command == ifl_pkg::CMD_PUSH) && !full |=> occ_r == $past(occ_r) + 1'b1)
    else $error("push did not grow the list");

  // the reported count follows the stored count
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_count_r == occ_r)
    else $error("reported count differs from stored count");

  // a full status only with a full list
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ifl_pkg::ST_FULL) |->
      out_count_r == ifl_pkg::CNT_W'(ifl_pkg::DEPTH))
    else $error("full status with room left");

  // a held result beat is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_value_r) && $stable(out_count_r))
    else $error("stalled result beat changed");
`endif

endmodule
